// File: rtl/core/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, register indexes and configuration types of the line-follow
// PID drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int GAIN_W     = 24;
  localparam int SPEED_W    = 8;
  localparam int THRESH_W   = 10;
  localparam int SUM_W      = 32;
  localparam int FRAC_BITS  = 22;
  localparam int ACC_W      = 58;
  localparam int CMD_W      = 60;
  localparam int HD_W       = 12;
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_KP_GAIN,
    REG_KI_GAIN,
    REG_KD_GAIN,
    REG_BASE_SPEED,
    REG_OUTPUT_LIMIT,
    REG_DARK_THRESHOLD,
    REG_STRAIGHT_COUNT_LIMIT,
    REG_STRAIGHT_SPEED
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   kp_gain;
    logic [GAIN_W-1:0]   ki_gain;
    logic [GAIN_W-1:0]   kd_gain;
    logic [SPEED_W-1:0]  base_speed;
    logic [SPEED_W-1:0]  output_limit;
    logic [THRESH_W-1:0] dark_threshold;
    logic [SPEED_W-1:0]  straight_count_limit;
    logic [SPEED_W-1:0]  straight_speed;
  } lfpd_cfg_t;

  localparam logic [GAIN_W-1:0]   KP_RESET       = 24'd15729;
  localparam logic [GAIN_W-1:0]   KI_RESET       = 24'd118;
  localparam logic [GAIN_W-1:0]   KD_RESET       = 24'd111411;
  localparam logic [SPEED_W-1:0]  BASE_RESET     = 8'd200;
  localparam logic [SPEED_W-1:0]  LIMIT_RESET    = 8'd255;
  localparam logic [THRESH_W-1:0] DARK_RESET     = 10'd80;
  localparam logic [SPEED_W-1:0]  COUNT_RESET    = 8'd20;
  localparam logic [SPEED_W-1:0]  STRAIGHT_RESET = 8'd250;

endpackage

// File: rtl/core/lfpd_if.sv
// ----------------------------------------------------------------------------
// lfpd_if
// Sample and wheel command channels, valid/ready with the payload alongside.
// ----------------------------------------------------------------------------
interface lfpd_in_if;
  import lfpd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lfpd_out_if;
  import lfpd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   left_reverse;
  logic [SPEED_W-1:0]     left_duty;
  logic                   right_reverse;
  logic [SPEED_W-1:0]     right_duty;
  logic                   straight_override;
  logic signed [HD_W-1:0] heading_diff;

  modport source (output valid, output left_reverse, output left_duty,
                  output right_reverse, output right_duty,
                  output straight_override, output heading_diff, input ready);
  modport sink   (input valid, input left_reverse, input left_duty,
                  input right_reverse, input right_duty,
                  input straight_override, input heading_diff, output ready);
endinterface

// File: rtl/core/line_follow_pid_drive.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive
// PID line follower for a differential drive: sensor error, PID sum, clamp
// with cross-coupled overflow, wheel direction and duty, dark-count override.
//
//   channel  dir  handshake              payload
//   in_ch    in   valid/ready            left_sample, right_sample
//   out_ch   out  valid/ready            reverse/duty per wheel, override, heading
//   apb      in   psel/penable/pwrite    8 registers at byte address 4*i
//
// Each item passes through the bit-serial error divider and then the bit-serial
// PID multiplier before its result reaches the output register.
// The next sample is taken once the previous result is in the output register.
// A stalled output holds its result; the core waits in its last step.
// Synchronous active-low reset clears the controller state and the registers.
// ----------------------------------------------------------------------------
module line_follow_pid_drive #(
  parameter int SENSOR_SPAN = 775
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lfpd_in_if.sink                          in_ch,
  lfpd_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfpd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lfpd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lfpd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import lfpd_pkg::*;

  localparam int SPAN_EFF = (SENSOR_SPAN > 0) ? SENSOR_SPAN : 1;
  localparam int NUM_MAX  = 1023 * 255 * 64;
  localparam int DVD_MAX  = 2 * NUM_MAX + SPAN_EFF;
  localparam int DVD_W    = $clog2(DVD_MAX + 1);
  localparam int QMAX     = DVD_MAX / (2 * SPAN_EFF);
  localparam int ERR_W    = $clog2(QMAX + 1) + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_SUM, ST_MAC, ST_CLAMP, ST_CROSS, ST_CMD, ST_OUT
  } state_t;

  typedef struct packed {
    logic               rev;
    logic [SPEED_W-1:0] duty;
  } wheel_t;

  function automatic wheel_t to_wheel(input logic signed [CMD_W-1:0] v);
    wheel_t                       w;
    logic [CMD_W-1:0]             mag;
    logic [CMD_W-FRAC_BITS-1:0]   whole;
    w.rev = v[CMD_W-1];
    mag   = v[CMD_W-1] ? (~v + 1'b1) : v;
    whole = mag[CMD_W-1:FRAC_BITS];
    w.duty = (|whole[CMD_W-FRAC_BITS-1:SPEED_W]) ? {SPEED_W{1'b1}} : whole[SPEED_W-1:0];
    return w;
  endfunction

  lfpd_cfg_t cfg;

  lfpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .reg_idx (paddr[APB_ADDR_W-1:2]),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t                  state_r;
  logic [SAMPLE_W-1:0]     left_r;
  logic [SAMPLE_W-1:0]     right_r;
  logic                    neg_r;
  logic signed [ERR_W-1:0] err_r;
  logic signed [ERR_W:0]   diff_r;
  logic signed [ERR_W-1:0] prev_err_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    ie_r;
  logic [SPEED_W-1:0]      dark_cnt_r;
  logic signed [CMD_W-1:0] wl_r;
  logic signed [CMD_W-1:0] wr_r;
  logic signed [CMD_W-1:0] cl_r;
  logic signed [CMD_W-1:0] cr_r;
  logic signed [CMD_W-1:0] nl_r;
  logic signed [CMD_W-1:0] nr_r;
  logic signed [HD_W-1:0]  hd_r;
  logic                    out_valid_r;
  logic                    out_lrev_r;
  logic [SPEED_W-1:0]      out_ldut_r;
  logic                    out_rrev_r;
  logic [SPEED_W-1:0]      out_rdut_r;
  logic                    out_ovr_r;
  logic signed [HD_W-1:0]  out_hd_r;

  // error numerator magnitude and rounding dividend
  logic signed [SAMPLE_W:0]  diff_lr;
  logic [SAMPLE_W:0]         absd_w;
  logic [SAMPLE_W-1:0]       absd;
  logic [SAMPLE_W+7:0]       prod255;
  logic [DVD_W-1:0]          dvd_nxt;
  logic                      div_start;
  logic                      div_done;
  logic [DVD_W-1:0]          quo;

  assign diff_lr   = signed'({1'b0, right_r}) - signed'({1'b0, left_r});
  assign absd_w    = diff_lr[SAMPLE_W] ? (~diff_lr + 1'b1) : diff_lr;
  assign absd      = absd_w[SAMPLE_W-1:0];
  assign prod255   = {absd, 8'd0} - {8'd0, absd};
  assign dvd_nxt   = DVD_W'({prod255, 7'd0}) + DVD_W'(SPAN_EFF);
  assign div_start = (state_r == ST_PREP);

  lfpd_div #(
    .DVD_W   (DVD_W),
    .DIVISOR (2 * SPAN_EFF)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_nxt),
    .done     (div_done),
    .quotient (quo)
  );

  // signed error, change of error and saturating integral
  logic signed [ERR_W-1:0] q_pos;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [ERR_W:0]   diff_nxt;
  logic signed [SUM_W:0]   sum_add;
  logic signed [SUM_W-1:0] sum_nxt;

  assign q_pos    = {1'b0, quo[ERR_W-2:0]};
  assign err_nxt  = neg_r ? -q_pos : q_pos;
  assign diff_nxt = {err_nxt[ERR_W-1], err_nxt} - {prev_err_r[ERR_W-1], prev_err_r};
  assign sum_add  = {sum_r[SUM_W-1], sum_r}
                  + {{(SUM_W + 1 - ERR_W){err_nxt[ERR_W-1]}}, err_nxt};

  always_comb begin
    sum_nxt = sum_add[SUM_W-1:0];
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      sum_nxt = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  logic                    mac_start;
  logic                    mac_done;
  logic signed [ACC_W-1:0] mac_acc;

  assign mac_start = (state_r == ST_SUM);

  lfpd_mac #(
    .ERR_W (ERR_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_start),
    .kp_gain (cfg.kp_gain),
    .ki_gain (cfg.ki_gain),
    .kd_gain (cfg.kd_gain),
    .err     (err_r),
    .sum     (sum_r),
    .diff    (diff_r),
    .done    (mac_done),
    .acc     (mac_acc)
  );

  // wheel commands in Q.22
  logic signed [CMD_W-1:0] base_q;
  logic signed [CMD_W-1:0] ctrl;
  logic signed [CMD_W-1:0] lim;
  logic signed [CMD_W-1:0] nlim;
  logic signed [CMD_W-1:0] cl_nxt;
  logic signed [CMD_W-1:0] cr_nxt;
  logic                    ie_nxt;
  logic signed [CMD_W-1:0] hdiff;
  logic [CMD_W-1:0]        hmag_w;
  logic [CMD_W-FRAC_BITS-1:0] hmag;
  logic signed [HD_W-1:0]  hd_nxt;

  assign base_q = signed'({{(CMD_W - SPEED_W - FRAC_BITS){1'b0}}, cfg.base_speed,
                           {FRAC_BITS{1'b0}}});
  assign ctrl   = {{(CMD_W - ACC_W){mac_acc[ACC_W-1]}}, mac_acc};
  assign lim    = signed'({{(CMD_W - SPEED_W - FRAC_BITS){1'b0}}, cfg.output_limit,
                           {FRAC_BITS{1'b0}}});
  assign nlim   = -lim;
  assign cl_nxt = (wl_r < nlim) ? nlim : ((wl_r > lim) ? lim : wl_r);
  assign cr_nxt = (wr_r < nlim) ? nlim : ((wr_r > lim) ? lim : wr_r);
  assign ie_nxt = (wr_r >= nlim) && (wr_r <= lim);

  assign hdiff  = wr_r - wl_r;
  assign hmag_w = hdiff[CMD_W-1] ? (~hdiff + 1'b1) : hdiff;
  assign hmag   = hmag_w[CMD_W-1:FRAC_BITS];

  always_comb begin
    if (hdiff[CMD_W-1]) begin
      // truncate toward zero, floor at the most negative code
      if (hmag > (CMD_W - FRAC_BITS)'(2048)) hd_nxt = {1'b1, {(HD_W-1){1'b0}}};
      else hd_nxt = HD_W'(0) - signed'(hmag[HD_W-1:0]);
    end else begin
      if (hmag > (CMD_W - FRAC_BITS)'(2047)) hd_nxt = {1'b0, {(HD_W-1){1'b1}}};
      else hd_nxt = signed'(hmag[HD_W-1:0]);
    end
  end

  // dark-count override and final wheel codes
  logic               both_dark;
  logic [SPEED_W-1:0] dark_nxt;
  logic               ovr_nxt;
  logic               out_load;
  wheel_t             wl_cmd;
  wheel_t             wr_cmd;

  assign both_dark = (left_r < cfg.dark_threshold) && (right_r < cfg.dark_threshold);
  assign dark_nxt  = !both_dark ? '0 : ((&dark_cnt_r) ? dark_cnt_r : dark_cnt_r + 1'b1);
  assign ovr_nxt   = dark_nxt > cfg.straight_count_limit;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  assign wl_cmd    = to_wheel(nl_r);
  assign wr_cmd    = to_wheel(nr_r);

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.left_reverse      = out_lrev_r;
  assign out_ch.left_duty         = out_ldut_r;
  assign out_ch.right_reverse     = out_rrev_r;
  assign out_ch.right_duty        = out_rdut_r;
  assign out_ch.straight_override = out_ovr_r;
  assign out_ch.heading_diff      = out_hd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_err_r  <= '0;
      sum_r       <= '0;
      ie_r        <= 1'b0;
      dark_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            left_r  <= in_ch.left_sample;
            right_r <= in_ch.right_sample;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          neg_r   <= diff_lr[SAMPLE_W];
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state_r <= ST_SUM;
        end
        ST_SUM: begin
          err_r  <= err_nxt;
          diff_r <= diff_nxt;
          if (ie_r) sum_r <= sum_nxt;
          state_r <= ST_MAC;
        end
        ST_MAC: begin
          if (mac_done) begin
            wl_r    <= base_q + ctrl;
            wr_r    <= base_q - ctrl;
            state_r <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          cl_r    <= cl_nxt;
          cr_r    <= cr_nxt;
          ie_r    <= ie_nxt;
          state_r <= ST_CROSS;
        end
        ST_CROSS: begin
          // pass the right-wheel overflow to the left wheel
          nl_r    <= cl_r + (wr_r - cr_r);
          hd_r    <= hd_nxt;
          state_r <= ST_CMD;
        end
        ST_CMD: begin
          nr_r    <= cr_r + (wl_r - nl_r);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_hd_r    <= hd_r;
            out_ovr_r   <= ovr_nxt;
            dark_cnt_r  <= dark_nxt;
            prev_err_r  <= err_r;
            if (ovr_nxt) begin
              out_lrev_r <= 1'b0;
              out_ldut_r <= cfg.straight_speed;
              out_rrev_r <= 1'b0;
              out_rdut_r <= cfg.straight_speed;
              sum_r      <= '0;
            end else begin
              out_lrev_r <= wl_cmd.rev;
              out_ldut_r <= wl_cmd.duty;
              out_rrev_r <= wr_cmd.rev;
              out_rdut_r <= wr_cmd.duty;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");

  a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == ST_MAC))
    else $error("multiplier finished outside the PID step");

  a_out_free_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("free output register not loaded");

  a_override_straight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovr_r) |->
      (!out_lrev_r && !out_rrev_r && out_ldut_r == out_rdut_r))
    else $error("override result does not drive straight");

endmodule

// File: rtl/core/lfpd_cfg.sv
// ----------------------------------------------------------------------------
// lfpd_cfg
// APB register file holding the gains, speeds and dark-detection settings.
// ----------------------------------------------------------------------------
module lfpd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfpd_pkg::REG_IDX_W-1:0]   reg_idx,
  input  logic [lfpd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lfpd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output lfpd_pkg::lfpd_cfg_t              cfg
);
  import lfpd_pkg::*;

  reg_idx_t  idx;
  logic      wr_en;
  lfpd_cfg_t cfg_r;

  assign idx    = reg_idx_t'(reg_idx);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain              <= KP_RESET;
      cfg_r.ki_gain              <= KI_RESET;
      cfg_r.kd_gain              <= KD_RESET;
      cfg_r.base_speed           <= BASE_RESET;
      cfg_r.output_limit         <= LIMIT_RESET;
      cfg_r.dark_threshold       <= DARK_RESET;
      cfg_r.straight_count_limit <= COUNT_RESET;
      cfg_r.straight_speed       <= STRAIGHT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_KP_GAIN:              cfg_r.kp_gain <= pwdata[GAIN_W-1:0];
        REG_KI_GAIN:              cfg_r.ki_gain <= pwdata[GAIN_W-1:0];
        REG_KD_GAIN:              cfg_r.kd_gain <= pwdata[GAIN_W-1:0];
        REG_BASE_SPEED:           cfg_r.base_speed <= pwdata[SPEED_W-1:0];
        REG_OUTPUT_LIMIT:         cfg_r.output_limit <= pwdata[SPEED_W-1:0];
        REG_DARK_THRESHOLD:       cfg_r.dark_threshold <= pwdata[THRESH_W-1:0];
        REG_STRAIGHT_COUNT_LIMIT: cfg_r.straight_count_limit <= pwdata[SPEED_W-1:0];
        REG_STRAIGHT_SPEED:       cfg_r.straight_speed <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_KP_GAIN:              prdata = APB_DATA_W'(cfg_r.kp_gain);
      REG_KI_GAIN:              prdata = APB_DATA_W'(cfg_r.ki_gain);
      REG_KD_GAIN:              prdata = APB_DATA_W'(cfg_r.kd_gain);
      REG_BASE_SPEED:           prdata = APB_DATA_W'(cfg_r.base_speed);
      REG_OUTPUT_LIMIT:         prdata = APB_DATA_W'(cfg_r.output_limit);
      REG_DARK_THRESHOLD:       prdata = APB_DATA_W'(cfg_r.dark_threshold);
      REG_STRAIGHT_COUNT_LIMIT: prdata = APB_DATA_W'(cfg_r.straight_count_limit);
      REG_STRAIGHT_SPEED:       prdata = APB_DATA_W'(cfg_r.straight_speed);
      default:                  prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/lfpd_div.sv
// ----------------------------------------------------------------------------
// lfpd_div
// Bit-serial restoring divider by a fixed divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lfpd_div #(
  parameter int DVD_W   = 26,
  parameter int DIVISOR = 1550
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int DVS_W = $clog2(DIVISOR + 1);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;

  // shift the next dividend bit into the partial remainder
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign ge       = rem_sh >= (DVS_W + 1)'(DIVISOR);
  assign rem_sub  = rem_sh - (DVS_W + 1)'(DIVISOR);
  assign done     = done_r;
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

endmodule

// File: rtl/core/lfpd_mac.sv
// ----------------------------------------------------------------------------
// lfpd_mac
// Bit-serial PID sum: kp*err + ki*sum + kd*diff, one gain bit a cycle, MSB first.
// ----------------------------------------------------------------------------
module lfpd_mac #(
  parameter int ERR_W = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [lfpd_pkg::GAIN_W-1:0]        kp_gain,
  input  logic [lfpd_pkg::GAIN_W-1:0]        ki_gain,
  input  logic [lfpd_pkg::GAIN_W-1:0]        kd_gain,
  input  logic signed [ERR_W-1:0]            err,
  input  logic signed [lfpd_pkg::SUM_W-1:0]  sum,
  input  logic signed [ERR_W:0]              diff,
  output logic                               done,
  output logic signed [lfpd_pkg::ACC_W-1:0]  acc
);
  import lfpd_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [GAIN_W-1:0]       kp_sr_r;
  logic [GAIN_W-1:0]       ki_sr_r;
  logic [GAIN_W-1:0]       kd_sr_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    done_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] err_x;
  logic signed [ACC_W-1:0] sum_x;
  logic signed [ACC_W-1:0] diff_x;
  logic signed [ACC_W-1:0] pp;
  logic signed [ACC_W-1:0] acc_nxt;

  assign err_x  = {{(ACC_W - ERR_W){err[ERR_W-1]}}, err};
  assign sum_x  = {{(ACC_W - SUM_W){sum[SUM_W-1]}}, sum};
  assign diff_x = {{(ACC_W - ERR_W - 1){diff[ERR_W]}}, diff};

  always_comb begin
    pp = '0;
    if (kp_sr_r[GAIN_W-1]) pp = pp + err_x;
    if (ki_sr_r[GAIN_W-1]) pp = pp + sum_x;
    if (kd_sr_r[GAIN_W-1]) pp = pp + diff_x;
    acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + pp;
  end

  assign done = done_r;
  assign acc  = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(GAIN_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kp_sr_r <= kp_gain;
      ki_sr_r <= ki_gain;
      kd_sr_r <= kd_gain;
      acc_r   <= '0;
    end else if (cnt_r != '0) begin
      kp_sr_r <= {kp_sr_r[GAIN_W-2:0], 1'b0};
      ki_sr_r <= {ki_sr_r[GAIN_W-2:0], 1'b0};
      kd_sr_r <= {kd_sr_r[GAIN_W-2:0], 1'b0};
      acc_r   <= acc_nxt;
    end
  end

endmodule
